/* src/scra_pkg.sv */
`timescale 1ns / 1ps

package scra_pkg;

   localparam int BLOCK_BYTES  = 64;
   localparam int HEADER_BYTES = 6;
   localparam int REPLY_BYTES  = HEADER_BYTES - 1;

   localparam int MEM_AW = (BLOCK_BYTES > 1) ? $clog2(BLOCK_BYTES) : 1;
   localparam int PTR_W  = $clog2(BLOCK_BYTES + 1);
   localparam int LEN_W  = $clog2(BLOCK_BYTES + 1);
   localparam int SLOT_W = $clog2(BLOCK_BYTES + HEADER_BYTES + 1);

   localparam logic [7:0] CRC_POLY  = 8'h8c;
   localparam logic [7:0] OP_WRITE  = 8'h01;
   localparam logic [7:0] OP_READ   = 8'h02;
   localparam logic [7:0] RSP_WRITE = 8'h81;
   localparam logic [7:0] RSP_READ  = 8'h82;
   localparam logic [7:0] IDLE_BYTE = 8'hff;
   localparam logic [3:0] MAX_ATTEMPTS_RESET = 4'd5;

   localparam logic [1:0] CMD_START_READ  = 2'd0;
   localparam logic [1:0] CMD_START_WRITE = 2'd1;
   localparam logic [1:0] CMD_LOAD        = 2'd2;
   localparam logic [1:0] CMD_EXCHANGE    = 2'd3;

   localparam logic [2:0] ST_NONE      = 3'd0;
   localparam logic [2:0] ST_OK        = 3'd1;
   localparam logic [2:0] ST_BAD_OP    = 3'd2;
   localparam logic [2:0] ST_ADDR_MISS = 3'd3;
   localparam logic [2:0] ST_CNT_MISS  = 3'd4;
   localparam logic [2:0] ST_RETRIES   = 3'd5;

   typedef struct packed {
      logic [1:0]  command;
      logic [15:0] address;
      logic [15:0] length;
      logic [7:0]  byte_req;
   } item_type;

   typedef struct packed {
      logic [7:0] tx_byte;
      logic       request_end;
      logic       data_valid;
      logic [7:0] read_byte;
      logic       done_res;
      logic [2:0] status;
      logic       retrying;
      logic [6:0] read_total;
      logic [3:0] attempt_number;
   } result_type;

   typedef struct packed {
      logic              wr_en;
      logic [MEM_AW-1:0] wr_addr;
      logic [7:0]        wr_data;
      logic [MEM_AW-1:0] rd_addr;
   } mem_ctl_type;

   function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] c;
      logic [7:0] d;
      logic       fb;
      c = crc;
      d = data;
      for (int k = 0; k < 8; k++) begin
         fb = c[0] ^ d[0];
         c  = c >> 1;
         d  = d >> 1;
         if (fb) begin
            c = c ^ CRC_POLY;
         end
      end
      return c;
   endfunction

endpackage

/* src/scra_payload_mem.sv */
`timescale 1ns / 1ps

module scra_payload_mem
   import scra_pkg::*;
(
   input  logic        clock,
   input  mem_ctl_type mem_ctl,
   input  logic        rd_en,
   output logic [7:0]  rd_data
);

   logic [7:0] mem [0:BLOCK_BYTES-1];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_ctl.wr_en) begin
         mem[mem_ctl.wr_addr] <= mem_ctl.wr_data;
      end
      if (rd_en) begin
         // same-edge write forwarding
         if (mem_ctl.wr_en && (mem_ctl.wr_addr == mem_ctl.rd_addr)) begin
            rd_data_ff <= mem_ctl.wr_data;
         end else begin
            rd_data_ff <= mem[mem_ctl.rd_addr];
         end
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/scra_engine.sv */
`timescale 1ns / 1ps

module scra_engine
   import scra_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        step,
   input  item_type    item,
   input  logic        csr_wr_en,
   input  logic [3:0]  csr_wr_data,
   input  logic [7:0]  mem_rd_data,
   output mem_ctl_type mem_ctl,
   output result_type  result
);

   localparam logic [1:0] PH_IDLE     = 2'd0;
   localparam logic [1:0] PH_REQUEST  = 2'd1;
   localparam logic [1:0] PH_RESPONSE = 2'd2;

   logic [1:0]        phase_ff, phase_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic              is_write_ff, is_write_in;
   logic [15:0]       addr_ff, addr_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic [7:0]        rep_ff [0:REPLY_BYTES-1];
   logic [7:0]        rep_in [0:REPLY_BYTES-1];
   logic [7:0]        rx_crc_ff, rx_crc_in;
   logic [7:0]        tx_crc_ff, tx_crc_in;
   logic [3:0]        attempt_ff, attempt_in;
   logic [PTR_W-1:0]  load_ptr_ff, load_ptr_in;
   logic [3:0]        max_att_ff;

   logic [15:0]       len16;
   logic [15:0]       rc;
   logic [LEN_W-1:0]  n_rd;
   logic [SLOT_W-1:0] total;
   logic [SLOT_W-1:0] pos;
   logic [SLOT_W-1:0] next_pos;
   logic [7:0]        hdr_byte;
   logic [7:0]        want_op;
   logic [7:0]        rx;

   assign len16   = 16'(len_ff);
   assign rc      = {rep_ff[4], rep_ff[3]};
   assign n_rd    = (rc < len16) ? rc[LEN_W-1:0] : len_ff;
   assign total   = SLOT_W'(HEADER_BYTES) + (is_write_ff ? SLOT_W'(len_ff) : SLOT_W'(0));
   assign pos     = slot_ff - SLOT_W'(HEADER_BYTES);
   assign want_op = is_write_ff ? RSP_WRITE : RSP_READ;
   assign rx      = item.byte_req;

   always_comb begin
      case (slot_ff[2:0])
         3'd0:    hdr_byte = is_write_ff ? OP_WRITE : OP_READ;
         3'd1:    hdr_byte = addr_ff[7:0];
         3'd2:    hdr_byte = addr_ff[15:8];
         3'd3:    hdr_byte = len16[7:0];
         3'd4:    hdr_byte = len16[15:8];
         default: hdr_byte = tx_crc_ff;
      endcase
   end

   always_comb begin
      phase_in    = phase_ff;
      slot_in     = slot_ff;
      is_write_in = is_write_ff;
      addr_in     = addr_ff;
      len_in      = len_ff;
      rep_in      = rep_ff;
      rx_crc_in   = rx_crc_ff;
      tx_crc_in   = tx_crc_ff;
      attempt_in  = attempt_ff;
      load_ptr_in = load_ptr_ff;
      result      = '0;
      result.tx_byte = IDLE_BYTE;
      mem_ctl.wr_en   = 1'b0;
      mem_ctl.wr_addr = load_ptr_ff[MEM_AW-1:0];
      mem_ctl.wr_data = rx;

      if (step) begin
         case (item.command)
            CMD_START_READ, CMD_START_WRITE: begin
               is_write_in = (item.command == CMD_START_WRITE);
               addr_in     = item.address;
               len_in      = (item.length > 16'(BLOCK_BYTES)) ? LEN_W'(BLOCK_BYTES)
                                                              : item.length[LEN_W-1:0];
               phase_in    = PH_REQUEST;
               slot_in     = '0;
               attempt_in  = 4'd1;
               load_ptr_in = '0;
            end
            CMD_LOAD: begin
               if (load_ptr_ff < PTR_W'(BLOCK_BYTES)) begin
                  mem_ctl.wr_en = 1'b1;
                  load_ptr_in   = load_ptr_ff + 1'b1;
               end
            end
            default: begin
               if (phase_ff == PH_REQUEST) begin
                  if (slot_ff < SLOT_W'(HEADER_BYTES)) begin
                     result.tx_byte = hdr_byte;
                     tx_crc_in = crc8_byte((slot_ff == '0) ? 8'h00 : tx_crc_ff, hdr_byte);
                  end else begin
                     result.tx_byte = mem_rd_data;
                  end
                  slot_in = slot_ff + 1'b1;
                  if (slot_in >= total) begin
                     result.request_end = 1'b1;
                     phase_in  = PH_RESPONSE;
                     slot_in   = '0;
                     rx_crc_in = 8'h00;
                  end
               end else if (phase_ff == PH_RESPONSE) begin
                  if (slot_ff < SLOT_W'(REPLY_BYTES)) begin
                     for (int i = 0; i < REPLY_BYTES; i++) begin
                        if (slot_ff == SLOT_W'(i)) begin
                           rep_in[i] = rx;
                        end
                     end
                     rx_crc_in = crc8_byte(rx_crc_ff, rx);
                     slot_in   = slot_ff + 1'b1;
                  end else if (slot_ff == SLOT_W'(REPLY_BYTES)) begin
                     if (rep_ff[0] != want_op) begin
                        result.done_res = 1'b1;
                        result.status   = ST_BAD_OP;
                     end else if (rep_ff[1] != addr_ff[7:0] || rep_ff[2] != addr_ff[15:8]) begin
                        result.done_res = 1'b1;
                        result.status   = ST_ADDR_MISS;
                     end else if (is_write_ff &&
                                  (rep_ff[3] != len16[7:0] || rep_ff[4] != len16[15:8])) begin
                        result.done_res = 1'b1;
                        result.status   = ST_CNT_MISS;
                     end else if (rx_crc_ff != rx) begin
                        if (({1'b0, attempt_ff} + 5'd1) > {1'b0, max_att_ff}) begin
                           result.done_res = 1'b1;
                           result.status   = ST_RETRIES;
                        end else begin
                           attempt_in      = attempt_ff + 1'b1;
                           result.retrying = 1'b1;
                           phase_in        = PH_REQUEST;
                           slot_in         = '0;
                        end
                     end else if (is_write_ff || n_rd == '0) begin
                        result.done_res = 1'b1;
                        result.status   = ST_OK;
                     end else begin
                        slot_in = slot_ff + 1'b1;
                     end
                     if (result.done_res) begin
                        phase_in = PH_IDLE;
                     end
                  end else begin
                     result.data_valid = 1'b1;
                     result.read_byte  = rx;
                     slot_in           = slot_ff + 1'b1;
                     if ((pos + 1'b1) >= SLOT_W'(n_rd)) begin
                        result.done_res   = 1'b1;
                        result.status     = ST_OK;
                        result.read_total = 7'(n_rd);
                        phase_in          = PH_IDLE;
                     end
                  end
               end
            end
         endcase
      end
      result.attempt_number = attempt_in;

      // prefetch address for the next item, from the post-step slot
      next_pos        = slot_in - SLOT_W'(HEADER_BYTES);
      mem_ctl.rd_addr = next_pos[MEM_AW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_IDLE;
         slot_ff     <= '0;
         is_write_ff <= 1'b0;
         addr_ff     <= '0;
         len_ff      <= '0;
         for (int i = 0; i < REPLY_BYTES; i++) begin
            rep_ff[i] <= '0;
         end
         rx_crc_ff   <= '0;
         tx_crc_ff   <= '0;
         attempt_ff  <= '0;
         load_ptr_ff <= '0;
         max_att_ff  <= MAX_ATTEMPTS_RESET;
      end else begin
         phase_ff    <= phase_in;
         slot_ff     <= slot_in;
         is_write_ff <= is_write_in;
         addr_ff     <= addr_in;
         len_ff      <= len_in;
         rep_ff      <= rep_in;
         rx_crc_ff   <= rx_crc_in;
         tx_crc_ff   <= tx_crc_in;
         attempt_ff  <= attempt_in;
         load_ptr_ff <= load_ptr_in;
         if (csr_wr_en) begin
            max_att_ff <= csr_wr_data;
         end
      end
   end

endmodule

/* src/spi_crc_framed_register_access_top.sv */
`timescale 1ns / 1ps
// Host-side engine for a CRC-checked SPI register protocol.
// req channel: one item per command. tuser carries the command (start read,
// start write, load payload byte, exchange one byte slot); tdata carries
// address, length and byte_req (the payload byte or the byte received from
// the device in that slot).
// rsp channel: exactly one item per request item, in order. tdata carries the
// byte to drive in the slot plus read data, done and status, retry flag, bytes
// read and attempt count; tlast marks the last request byte, tuser marks a
// valid read data byte.
// csr port: csr_wr_en/csr_wr_data set max_attempts (reset value 5); write it
// only while no transaction is running.
// Path: a req item passes the input register, then the result register, before
// it shows on rsp. Throughput: one item per cycle while rsp_tready is high; the
// slot state and the one-byte CRC update are computed combinationally in a step,
// and the payload RAM read is issued when the item enters the input register.
// Reset (synchronous): both stages empty, engine idle, max_attempts = 5.
// Stall: when rsp_tready is low the result holds, the input register keeps
// one more item, and then req_tready drops until the result is taken.

module spi_crc_framed_register_access_top
   import scra_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // address[15:0], length[31:16], byte_req[39:32]
   input  logic [1:0]  req_tuser,   // command[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // tx_byte[7:0], read_byte[15:8], done_res[16],
                                    // status[19:17], retrying[20], read_total[27:21],
                                    // attempt_number[31:28]
   output logic        rsp_tlast,   // request_end
   output logic        rsp_tuser,   // data_valid
   input  logic        csr_wr_en,
   input  logic [3:0]  csr_wr_data
);

   logic        in_valid_ff;
   item_type    item_ff;
   logic        rsp_valid_ff;
   result_type  rsp_ff;
   logic        step;
   logic        accept;
   result_type  result;
   mem_ctl_type mem_ctl;
   logic [7:0]  mem_rd_data;

   assign step       = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || step;
   assign accept     = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            in_valid_ff <= 1'b1;
         end else if (step) begin
            in_valid_ff <= 1'b0;
         end
         if (step) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff.command  <= req_tuser;
         item_ff.address  <= req_tdata[15:0];
         item_ff.length   <= req_tdata[31:16];
         item_ff.byte_req <= req_tdata[39:32];
      end
      if (step) begin
         rsp_ff <= result;
      end
   end

   scra_engine u_engine (
      .clock       (clock),
      .reset       (reset),
      .step        (step),
      .item        (item_ff),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .mem_rd_data (mem_rd_data),
      .mem_ctl     (mem_ctl),
      .result      (result)
   );

   scra_payload_mem u_mem (
      .clock   (clock),
      .mem_ctl (mem_ctl),
      .rd_en   (accept),
      .rd_data (mem_rd_data)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_ff.attempt_number, rsp_ff.read_total, rsp_ff.retrying,
                        rsp_ff.status, rsp_ff.done_res, rsp_ff.read_byte, rsp_ff.tx_byte};
   assign rsp_tlast  = rsp_ff.request_end;
   assign rsp_tuser  = rsp_ff.data_valid;

endmodule

/* src/scra_checker.sv */
`timescale 1ns / 1ps

module scra_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic        rsp_tlast,
   input logic        rsp_tuser
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tlast) && $stable(rsp_tuser))
      else $error("rsp item changed while stalled");

   a_empty_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp valid right after reset");

   a_status_with_done: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[16] == (rsp_tdata[19:17] != 3'd0)))
      else $error("status without done or done without status");

   a_data_in_response: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser || rsp_tdata[20]) |->
         !rsp_tlast && (rsp_tdata[7:0] == 8'hff))
      else $error("read data or retry flagged during request phase");

endmodule

bind spi_crc_framed_register_access_top scra_checker u_scra_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .rsp_tuser  (rsp_tuser)
);

/* verif/spi_crc_framed_register_access_top_tb.sv */
`timescale 1ns / 1ps

module spi_crc_framed_register_access_top_tb
   import scra_pkg::*;
();

   typedef enum logic [1:0] {ENG_IDLE, ENG_REQUEST, ENG_RESPONSE} eng_phase_type;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata   = '0;
   logic [1:0]  req_tuser   = '0;
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [31:0] rsp_tdata;
   logic        rsp_tlast;
   logic        rsp_tuser;
   logic        csr_wr_en   = 1'b0;
   logic [3:0]  csr_wr_data = '0;

   spi_crc_framed_register_access_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   item_type   cmd_queue[$];
   result_type predicted_rsp[$];
   int         err_count = 0;

   // engine shadow
   logic [7:0]    m_hdr[HEADER_BYTES];
   logic [7:0]    m_payload[BLOCK_BYTES];
   logic [7:0]    m_reply[REPLY_BYTES];
   eng_phase_type m_phase;
   int            m_slot;
   bit            m_write;
   logic [7:0]    m_reply_crc;
   int            m_attempts;
   logic [3:0]    m_max_attempts;
   int            m_load_ptr;

   // stimulus bookkeeping
   int         gen_count  = 0;
   int         gen_ptr    = 0;
   int         gen_prefix = 0;
   int         gen_max    = MAX_ATTEMPTS_RESET;

   task automatic report_error(input string msg);
      if (err_count < 200) begin
         $display("ERROR %0t ns: %s", $time, msg);
      end
      err_count++;
   endtask

   function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] r;
      r = crc ^ data;
      repeat (8) r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
      return r;
   endfunction

   function automatic void engine_reset();
      foreach (m_hdr[k]) m_hdr[k] = '0;
      foreach (m_payload[k]) m_payload[k] = '0;
      foreach (m_reply[k]) m_reply[k] = '0;
      m_phase        = ENG_IDLE;
      m_slot         = 0;
      m_write        = 1'b0;
      m_reply_crc    = '0;
      m_attempts     = 0;
      m_max_attempts = MAX_ATTEMPTS_RESET;
      m_load_ptr     = 0;
   endfunction

   function automatic result_type engine_step(input item_type it);
      result_type r;
      int         clamp_len;
      int         total;
      int         take;
      int         rc;
      logic [7:0] want_op;
      r = '0;
      r.tx_byte = IDLE_BYTE;
      case (it.command)
         CMD_START_READ, CMD_START_WRITE: begin
            clamp_len = (it.length > BLOCK_BYTES) ? BLOCK_BYTES : it.length;
            m_write  = (it.command == CMD_START_WRITE);
            m_hdr[0] = m_write ? OP_WRITE : OP_READ;
            m_hdr[1] = it.address[7:0];
            m_hdr[2] = it.address[15:8];
            m_hdr[3] = clamp_len[7:0];
            m_hdr[4] = clamp_len[15:8];
            m_hdr[5] = '0;
            for (int k = 0; k < REPLY_BYTES; k++) m_hdr[5] = crc8_next(m_hdr[5], m_hdr[k]);
            m_phase    = ENG_REQUEST;
            m_slot     = 0;
            m_attempts = 1;
            m_load_ptr = 0;
         end
         CMD_LOAD: begin
            if (m_load_ptr < BLOCK_BYTES) begin
               m_payload[m_load_ptr] = it.byte_req;
               m_load_ptr++;
            end
         end
         CMD_EXCHANGE: begin
            take = {m_hdr[4], m_hdr[3]};
            rc   = {m_reply[4], m_reply[3]};
            if (rc < take) take = rc;
            if (m_phase == ENG_REQUEST) begin
               total = HEADER_BYTES + (m_write ? int'({m_hdr[4], m_hdr[3]}) : 0);
               r.tx_byte = (m_slot < HEADER_BYTES) ? m_hdr[m_slot]
                                                   : m_payload[m_slot - HEADER_BYTES];
               m_slot++;
               if (m_slot >= total) begin
                  r.request_end = 1'b1;
                  m_phase       = ENG_RESPONSE;
                  m_slot        = 0;
                  m_reply_crc   = '0;
               end
            end else if (m_phase == ENG_RESPONSE) begin
               if (m_slot < REPLY_BYTES) begin
                  m_reply[m_slot] = it.byte_req;
                  m_reply_crc     = crc8_next(m_reply_crc, it.byte_req);
                  m_slot++;
               end else if (m_slot == REPLY_BYTES) begin
                  want_op = m_write ? RSP_WRITE : RSP_READ;
                  if (m_reply[0] != want_op) begin
                     r.status = ST_BAD_OP;
                  end else if (m_reply[1] != m_hdr[1] || m_reply[2] != m_hdr[2]) begin
                     r.status = ST_ADDR_MISS;
                  end else if (m_write && (m_reply[3] != m_hdr[3] || m_reply[4] != m_hdr[4])) begin
                     r.status = ST_CNT_MISS;
                  end else if (m_reply_crc != it.byte_req) begin
                     if (m_attempts + 1 > m_max_attempts) begin
                        r.status = ST_RETRIES;
                     end else begin
                        m_attempts++;
                        r.retrying = 1'b1;
                        m_phase    = ENG_REQUEST;
                        m_slot     = 0;
                     end
                  end else if (m_write || take == 0) begin
                     r.status = ST_OK;
                  end else begin
                     m_slot++;
                  end
                  if (r.status != ST_NONE) begin
                     r.done_res = 1'b1;
                     m_phase    = ENG_IDLE;
                  end
               end else begin
                  r.data_valid = 1'b1;
                  r.read_byte  = it.byte_req;
                  m_slot++;
                  if (m_slot - HEADER_BYTES >= take) begin
                     r.done_res   = 1'b1;
                     r.status     = ST_OK;
                     r.read_total = take[6:0];
                     m_phase      = ENG_IDLE;
                  end
               end
            end
         end
      endcase
      r.attempt_number = m_attempts[3:0];
      return r;
   endfunction

   // ---------------- stimulus ----------------

   task automatic push_item(input logic [1:0] cmd, input int addr, input int len, input int data);
      item_type it;
      it.command  = cmd;
      it.address  = addr[15:0];
      it.length   = len[15:0];
      it.byte_req = data[7:0];
      cmd_queue.push_back(it);
      gen_count++;
      if (cmd == CMD_LOAD) begin
         if (gen_ptr < BLOCK_BYTES) begin
            gen_ptr++;
            if (gen_ptr > gen_prefix) gen_prefix = gen_ptr;
         end
      end else if (cmd != CMD_EXCHANGE) begin
         gen_ptr = 0;
      end
   endtask

   task automatic push_slot(input int data);
      push_item(CMD_EXCHANGE, $urandom_range(0, 65535), $urandom_range(0, 65535), data);
   endtask

   task automatic push_reply(input logic [7:0] op, input logic [7:0] alo, input logic [7:0] ahi,
                             input logic [7:0] clo, input logic [7:0] chi, input bit bad_crc);
      logic [7:0] crc;
      crc = crc8_next(crc8_next(crc8_next(crc8_next(crc8_next(8'h00, op), alo), ahi), clo), chi);
      if (bad_crc) crc = crc ^ (8'h01 << $urandom_range(0, 7));
      push_slot(op);
      push_slot(alo);
      push_slot(ahi);
      push_slot(clo);
      push_slot(chi);
      push_slot(crc);
   endtask

   task automatic queue_transfer(input bit wr);
      int         addr;
      int         lenf;
      int         n;
      int         loads;
      int         rc;
      int         tries;
      logic [7:0] op;
      logic [7:0] alo;
      logic [7:0] ahi;
      logic [7:0] clo;
      logic [7:0] chi;
      bit         hdr_bad;
      bit         bad_crc;
      bit         stubborn;
      addr = $urandom_range(0, 65535);
      case ($urandom_range(0, 11))
         0:       lenf = BLOCK_BYTES;
         1:       lenf = $urandom_range(BLOCK_BYTES + 1, 65535);
         default: lenf = $urandom_range(0, 8);
      endcase
      n = (lenf > BLOCK_BYTES) ? BLOCK_BYTES : lenf;
      push_item(wr ? CMD_START_WRITE : CMD_START_READ, addr, lenf, $urandom_range(0, 255));
      if (wr && n <= gen_prefix && $urandom_range(0, 3) == 0) begin
         loads = $urandom_range(0, n);
      end else if (wr) begin
         loads = n + $urandom_range(0, 2);
      end else begin
         loads = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 3) : 0;
      end
      repeat (loads) push_item(CMD_LOAD, $urandom_range(0, 65535), $urandom_range(0, 65535),
                               $urandom_range(0, 255));
      stubborn = ($urandom_range(0, (gen_max <= 5) ? 7 : 39) == 0);
      tries = 0;
      forever begin
         tries++;
         for (int s = 0; s < HEADER_BYTES + (wr ? n : 0); s++) begin
            if ($urandom_range(0, 31) == 0) begin
               push_item(CMD_LOAD, $urandom_range(0, 65535), $urandom_range(0, 65535),
                         $urandom_range(0, 255));
            end
            push_slot($urandom_range(0, 255));
         end
         // abandoned; the next start cuts it off
         if ($urandom_range(0, 24) == 0) return;
         op  = wr ? RSP_WRITE : RSP_READ;
         alo = addr[7:0];
         ahi = addr[15:8];
         if (wr) begin
            rc = n;
         end else begin
            case ($urandom_range(0, 9))
               0, 1:    rc = $urandom_range(0, n);
               2:       rc = $urandom_range(0, 65535);
               3:       rc = n + $urandom_range(1, 3);
               default: rc = n;
            endcase
         end
         clo = rc[7:0];
         chi = rc[15:8];
         case ($urandom_range(0, 29))
            0: op  = 8'($urandom_range(0, 255));
            1: alo = alo ^ (8'h01 << $urandom_range(0, 7));
            2: ahi = ahi ^ (8'h01 << $urandom_range(0, 7));
            3: clo = clo ^ (8'h01 << $urandom_range(0, 7));
            4: chi = chi ^ (8'h01 << $urandom_range(0, 7));
            default: ;
         endcase
         rc = {chi, clo};
         hdr_bad = (op != (wr ? RSP_WRITE : RSP_READ)) || alo != addr[7:0] ||
                   ahi != addr[15:8] || (wr && rc != n);
         bad_crc = stubborn || $urandom_range(0, 4) == 0;
         push_reply(op, alo, ahi, clo, chi, bad_crc);
         if (hdr_bad) return;
         if (!bad_crc) begin
            if (!wr) repeat ((rc < n) ? rc : n) push_slot($urandom_range(0, 255));
            return;
         end
         if (tries + 1 > gen_max) return;
      end
   endtask

   task automatic queue_noise();
      logic [1:0] cmd;
      int         lenf;
      cmd = 2'($urandom_range(0, 3));
      if (cmd == CMD_START_WRITE) begin
         if (gen_prefix == BLOCK_BYTES && $urandom_range(0, 1) == 0) begin
            lenf = $urandom_range(BLOCK_BYTES + 1, 65535);
         end else begin
            lenf = $urandom_range(0, gen_prefix);
         end
         push_item(cmd, $urandom_range(0, 65535), lenf, $urandom_range(0, 255));
      end else begin
         push_item(cmd, $urandom_range(0, 65535), $urandom_range(0, 65535),
                   $urandom_range(0, 255));
      end
   endtask

   task automatic queue_random(input int count);
      int target;
      target = gen_count + count;
      while (gen_count < target) begin
         if ($urandom_range(0, 9) < 8) begin
            queue_transfer(1'($urandom_range(0, 1)));
         end else begin
            repeat ($urandom_range(1, 4)) queue_noise();
         end
      end
   endtask

   task automatic wait_drained();
      while (cmd_queue.size() != 0 || req_tvalid || predicted_rsp.size() != 0) begin
         @(negedge clock);
      end
      repeat (4) @(posedge clock);
   endtask

   task automatic write_max_attempts(input logic [3:0] value);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      m_max_attempts = value;
      gen_max        = value;
   endtask

   // ---------------- driver ----------------

   item_type cur_item;
   int       burst_left = 0;
   int       gap_left   = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         engine_reset();
      end else begin
         if (req_tvalid && req_tready) begin
            predicted_rsp.push_back(engine_step(cur_item));
         end
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else if (cmd_queue.size() != 0) begin
               cur_item = cmd_queue.pop_front();
               req_tdata  <= {cur_item.byte_req, cur_item.length, cur_item.address};
               req_tuser  <= cur_item.command;
               req_tvalid <= 1'b1;
               burst_left--;
               if (burst_left <= 0) begin
                  burst_left = ($urandom_range(0, 7) == 0) ? 48 : $urandom_range(1, 12);
                  gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
               end
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // ---------------- monitor ----------------

   logic [31:0] rx_cycle = '0;

   task automatic check_result();
      result_type want;
      result_type got;
      if (predicted_rsp.size() == 0) begin
         report_error($sformatf("unexpected rsp item, tdata %h", rsp_tdata));
         return;
      end
      want = predicted_rsp.pop_front();
      got.tx_byte        = rsp_tdata[7:0];
      got.read_byte      = rsp_tdata[15:8];
      got.done_res       = rsp_tdata[16];
      got.status         = rsp_tdata[19:17];
      got.retrying       = rsp_tdata[20];
      got.read_total     = rsp_tdata[27:21];
      got.attempt_number = rsp_tdata[31:28];
      got.request_end    = rsp_tlast;
      got.data_valid     = rsp_tuser;
      if (got.tx_byte !== want.tx_byte)
         report_error($sformatf("tx_byte %h, want %h", got.tx_byte, want.tx_byte));
      if (got.request_end !== want.request_end)
         report_error($sformatf("request_end %b, want %b", got.request_end, want.request_end));
      if (got.data_valid !== want.data_valid)
         report_error($sformatf("data_valid %b, want %b", got.data_valid, want.data_valid));
      if (got.read_byte !== want.read_byte)
         report_error($sformatf("read_byte %h, want %h", got.read_byte, want.read_byte));
      if (got.done_res !== want.done_res)
         report_error($sformatf("done_res %b, want %b", got.done_res, want.done_res));
      if (got.status !== want.status)
         report_error($sformatf("status %0d, want %0d", got.status, want.status));
      if (got.retrying !== want.retrying)
         report_error($sformatf("retrying %b, want %b", got.retrying, want.retrying));
      if (got.read_total !== want.read_total)
         report_error($sformatf("read_total %0d, want %0d", got.read_total, want.read_total));
      if (got.attempt_number !== want.attempt_number)
         report_error($sformatf("attempt_number %0d, want %0d",
                                got.attempt_number, want.attempt_number));
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) check_result();
         rx_cycle <= rx_cycle + 1;
         case (rx_cycle[8:7])
            2'd0:    rsp_tready <= 1'b1;
            2'd1:    rsp_tready <= ($urandom_range(0, 3) != 0);
            2'd2:    rsp_tready <= ((rx_cycle % 7) < 3);
            default: rsp_tready <= ($urandom_range(0, 9) < 3);
         endcase
      end
   end

   // ---------------- sequence ----------------

   initial begin
      int         budget[4];
      logic [3:0] setting[4];
      budget  = '{220, 150, 150, 300};
      setting = '{4'd15, 4'd0, 4'd1, 4'($urandom_range(2, 14))};
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      push_item(CMD_EXCHANGE, 16'hffff, 16'hffff, 8'hff);   // idle slot
      push_item(CMD_LOAD, 16'h0000, 16'h0000, 8'hff);
      push_item(CMD_LOAD, 16'h0000, 16'h0000, 8'h00);
      push_item(CMD_START_WRITE, 16'hffff, 16'h0001, 8'h00);
      repeat (7) push_slot($urandom_range(0, 255));
      // new start while the write is still waiting on its reply
      push_item(CMD_START_READ, 16'h0000, 16'hffff, 8'h00);
      repeat (6) push_slot($urandom_range(0, 255));
      push_reply(RSP_READ, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
      wait_drained();

      for (int p = 0; p < 4; p++) begin
         write_max_attempts(setting[p]);
         queue_random(budget[p]);
         wait_drained();
      end

      if (err_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule

/* filelist.f */
src/scra_pkg.sv
src/scra_payload_mem.sv
src/scra_engine.sv
src/spi_crc_framed_register_access_top.sv
src/scra_checker.sv
verif/spi_crc_framed_register_access_top_tb.sv
